### hw/rtl/tmsag_pkg.sv
package tmsag_pkg;

   localparam int MAX_SETS   = 8;
   localparam int SET_BITS   = $clog2(MAX_SETS);
   localparam int COUNT_BITS = $clog2(MAX_SETS + 1);
   localparam int ID_BITS    = 16;
   localparam int STEP_BITS  = $clog2(ID_BITS);

   localparam logic [ID_BITS-1:0] ID_MAX = '1;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_CELL = 1'b1;

   // register word index on the csr port
   localparam logic [2:0] REG_TILE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_TILE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_MAP_WIDTH   = 3'd2;
   localparam logic [2:0] REG_MAP_HEIGHT  = 3'd3;
   localparam logic [2:0] REG_VIEW_LEFT   = 3'd4;
   localparam logic [2:0] REG_VIEW_TOP    = 3'd5;
   localparam logic [2:0] REG_VIEW_WIDTH  = 3'd6;
   localparam logic [2:0] REG_VIEW_HEIGHT = 3'd7;

   typedef struct packed {
      logic        kind;
      logic [15:0] texture_width;
      logic [15:0] texture_height;
      logic [11:0] cell_column;
      logic [11:0] cell_row;
      logic [15:0] tile_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  set_index;
      logic [15:0] source_x;
      logic [15:0] source_y;
      logic [19:0] dest_x;
      logic [19:0] dest_y;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [ID_BITS-1:0] dividend;
      logic [ID_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic               busy;
      logic [ID_BITS-1:0] quotient;
      logic [ID_BITS-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic [ID_BITS:0]   first_id;
      logic [ID_BITS:0]   last_id;
      logic [ID_BITS-1:0] columns;
   } set_entry_type;

endpackage

### hw/rtl/tmsag_divider.sv
module tmsag_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  tmsag_pkg::div_req_type div_req,
   output tmsag_pkg::div_rsp_type div_rsp
);
   import tmsag_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic                 zero_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic [ID_BITS-1:0]   quo_ff;
   logic [ID_BITS-1:0]   rem_ff;
   logic [ID_BITS-1:0]   dvs_ff;

   logic [ID_BITS:0]     shifted;
   logic [ID_BITS:0]     diff;
   logic                 fits;

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[ID_BITS-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            quo_ff  <= div_req.dividend;
            rem_ff  <= '0;
            dvs_ff  <= div_req.divisor;
            zero_ff <= (div_req.divisor == '0);
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[ID_BITS-1:0] : shifted[ID_BITS-1:0];
            quo_ff <= {quo_ff[ID_BITS-2:0], fits};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_BITS'(ID_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // division by zero gives zero
   assign div_rsp.done      = done_ff;
   assign div_rsp.busy      = busy_ff;
   assign div_rsp.quotient  = zero_ff ? '0 : quo_ff;
   assign div_rsp.remainder = zero_ff ? '0 : rem_ff;

endmodule

### hw/rtl/tile_map_sprite_address_gen_core.sv
// channel  ports                          word
// req      req_valid req_ready req_data   load (texture size) or map cell
// rsp      rsp_valid rsp_ready rsp_data   set index, source and dest pixels
// csr      csr_psel .. csr_prdata         eight tile, map and view registers
//
// a load runs two divides on the shared divider, one multiply and one table
// write; it is dropped with no divide when the table is full. a cell is
// dropped on the window and id check, else searches the set table, divides
// and uses the shared multiplier four times. req_ready is high only when idle;
// a result waits in the output register, a later one stalls while it is full.
// synchronous reset clears the set count and id total, not the set table.
module tile_map_sprite_address_gen_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tmsag_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tmsag_pkg::rsp_type rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import tmsag_pkg::*;

   typedef enum logic [3:0] {
      IDLE,
      LOAD_COLS_GO,
      LOAD_COLS_WAIT,
      LOAD_ROWS_GO,
      LOAD_ROWS_WAIT,
      LOAD_AREA,
      LOAD_WRITE,
      CELL_CHECK,
      SRCH_RD,
      SRCH_CMP,
      CELL_DIV_GO,
      CELL_DIV_WAIT,
      MUL_SX,
      MUL_SY,
      MUL_DX,
      MUL_DY
   } state_type;

   // ---------------- configuration registers
   logic [8:0]  tile_width_ff;
   logic [8:0]  tile_height_ff;
   logic [12:0] map_width_ff;
   logic [12:0] map_height_ff;
   logic [15:0] view_left_ff;
   logic [15:0] view_top_ff;
   logic [14:0] view_width_ff;
   logic [14:0] view_height_ff;
   logic [2:0]  reg_index;
   logic        csr_write;

   assign reg_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff  <= 9'd16;
         tile_height_ff <= 9'd16;
         map_width_ff   <= 13'd64;
         map_height_ff  <= 13'd64;
         view_left_ff   <= '0;
         view_top_ff    <= '0;
         view_width_ff  <= 15'd64;
         view_height_ff <= 15'd64;
      end else if (csr_write) begin
         case (reg_index)
            REG_TILE_WIDTH:  tile_width_ff  <= csr_pwdata[8:0];
            REG_TILE_HEIGHT: tile_height_ff <= csr_pwdata[8:0];
            REG_MAP_WIDTH:   map_width_ff   <= csr_pwdata[12:0];
            REG_MAP_HEIGHT:  map_height_ff  <= csr_pwdata[12:0];
            REG_VIEW_LEFT:   view_left_ff   <= csr_pwdata[15:0];
            REG_VIEW_TOP:    view_top_ff    <= csr_pwdata[15:0];
            REG_VIEW_WIDTH:  view_width_ff  <= csr_pwdata[14:0];
            REG_VIEW_HEIGHT: view_height_ff <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_TILE_WIDTH:  csr_prdata = {23'd0, tile_width_ff};
         REG_TILE_HEIGHT: csr_prdata = {23'd0, tile_height_ff};
         REG_MAP_WIDTH:   csr_prdata = {19'd0, map_width_ff};
         REG_MAP_HEIGHT:  csr_prdata = {19'd0, map_height_ff};
         REG_VIEW_LEFT:   csr_prdata = {{16{view_left_ff[15]}}, view_left_ff};
         REG_VIEW_TOP:    csr_prdata = {{16{view_top_ff[15]}}, view_top_ff};
         REG_VIEW_WIDTH:  csr_prdata = {17'd0, view_width_ff};
         REG_VIEW_HEIGHT: csr_prdata = {17'd0, view_height_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer state
   state_type            state_ff;
   req_type              req_ff;
   logic [COUNT_BITS-1:0] set_count_ff;
   logic [COUNT_BITS-1:0] srch_ff;
   logic [ID_BITS-1:0]   id_total_ff;
   logic [ID_BITS-1:0]   opnd_a_ff;
   logic [ID_BITS-1:0]   opnd_b_ff;
   logic [2*ID_BITS-1:0] area_ff;
   rsp_type              res_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_load;

   set_entry_type        set_mem [MAX_SETS];
   set_entry_type        rd_data_ff;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   tmsag_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------- shared divider operands
   logic table_full;
   assign table_full = (set_count_ff == COUNT_BITS'(MAX_SETS));

   always_comb begin
      div_req.start = ((state_ff == LOAD_COLS_GO) && !table_full) ||
                      (state_ff == LOAD_ROWS_GO) || (state_ff == CELL_DIV_GO);
      case (state_ff)
         LOAD_COLS_GO: begin
            div_req.dividend = req_ff.texture_width;
            div_req.divisor  = {7'd0, tile_width_ff};
         end
         LOAD_ROWS_GO: begin
            div_req.dividend = req_ff.texture_height;
            div_req.divisor  = {7'd0, tile_height_ff};
         end
         default: begin
            div_req.dividend = opnd_a_ff;
            div_req.divisor  = opnd_b_ff;
         end
      endcase
   end

   // ---------------- shared multiplier
   logic [ID_BITS-1:0]   mul_a;
   logic [ID_BITS-1:0]   mul_b;
   logic [2*ID_BITS-1:0] product;

   always_comb begin
      case (state_ff)
         MUL_SX: begin
            mul_a = opnd_b_ff;
            mul_b = {7'd0, tile_width_ff};
         end
         MUL_SY: begin
            mul_a = opnd_a_ff;
            mul_b = {7'd0, tile_height_ff};
         end
         MUL_DX: begin
            mul_a = {4'd0, req_ff.cell_column};
            mul_b = {7'd0, tile_width_ff};
         end
         MUL_DY: begin
            mul_a = {4'd0, req_ff.cell_row};
            mul_b = {7'd0, tile_height_ff};
         end
         LOAD_AREA: begin
            mul_a = opnd_a_ff;
            mul_b = opnd_b_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = mul_a * mul_b;

   // ---------------- load arithmetic
   logic [2*ID_BITS:0]  sum_total;
   logic [ID_BITS-1:0]  last_id;
   set_entry_type       new_entry;

   assign sum_total = {{(ID_BITS+1){1'b0}}, id_total_ff} + {1'b0, area_ff};
   // running total saturates at the top id
   assign last_id   = (sum_total > {{(ID_BITS+1){1'b0}}, ID_MAX}) ?
                      ID_MAX : sum_total[ID_BITS-1:0];

   assign new_entry.first_id = {1'b0, id_total_ff} + 1'b1;
   assign new_entry.last_id  = {1'b0, last_id};
   assign new_entry.columns  = opnd_a_ff;

   always_ff @(posedge clock) begin
      if (state_ff == LOAD_WRITE) begin
         set_mem[set_count_ff[SET_BITS-1:0]] <= new_entry;
      end
      rd_data_ff <= set_mem[srch_ff[SET_BITS-1:0]];
   end

   // ---------------- cell checks
   logic signed [17:0] col_s;
   logic signed [17:0] row_s;
   logic signed [17:0] left_s;
   logic signed [17:0] top_s;
   logic signed [17:0] right_s;
   logic signed [17:0] bottom_s;
   logic               cell_visible;
   logic               id_ok;
   logic [ID_BITS:0]   id_wide;
   logic               set_hit;

   assign col_s    = signed'({6'd0, req_ff.cell_column});
   assign row_s    = signed'({6'd0, req_ff.cell_row});
   assign left_s   = signed'({{2{view_left_ff[15]}}, view_left_ff});
   assign top_s    = signed'({{2{view_top_ff[15]}}, view_top_ff});
   assign right_s  = left_s + signed'({3'd0, view_width_ff});
   assign bottom_s = top_s + signed'({3'd0, view_height_ff});

   // window clipped to the map; cells are never negative
   assign cell_visible = (col_s >= left_s) && (col_s < right_s) &&
                         ({1'b0, req_ff.cell_column} < map_width_ff) &&
                         (row_s >= top_s) && (row_s < bottom_s) &&
                         ({1'b0, req_ff.cell_row} < map_height_ff);
   assign id_ok   = (req_ff.tile_id != '0) && (req_ff.tile_id <= id_total_ff);
   assign id_wide = {1'b0, req_ff.tile_id};
   assign set_hit = (id_wide >= rd_data_ff.first_id) && (id_wide <= rd_data_ff.last_id);

   // last step hands the word over once the output register is free
   assign rsp_load = (state_ff == MUL_DY) && (!rsp_valid_ff || rsp_ready);

   // ---------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         set_count_ff <= '0;
         id_total_ff  <= '0;
         srch_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= (req_data.kind == KIND_CELL) ? CELL_CHECK : LOAD_COLS_GO;
               end
            end
            LOAD_COLS_GO: begin
               state_ff <= table_full ? IDLE : LOAD_COLS_WAIT;
            end
            LOAD_COLS_WAIT: begin
               if (div_rsp.done) begin
                  opnd_a_ff <= div_rsp.quotient;
                  state_ff  <= LOAD_ROWS_GO;
               end
            end
            LOAD_ROWS_GO: begin
               state_ff <= LOAD_ROWS_WAIT;
            end
            LOAD_ROWS_WAIT: begin
               if (div_rsp.done) begin
                  opnd_b_ff <= div_rsp.quotient;
                  state_ff  <= LOAD_AREA;
               end
            end
            LOAD_AREA: begin
               area_ff  <= product;
               state_ff <= LOAD_WRITE;
            end
            LOAD_WRITE: begin
               id_total_ff  <= last_id;
               set_count_ff <= set_count_ff + 1'b1;
               state_ff     <= IDLE;
            end
            CELL_CHECK: begin
               srch_ff  <= '0;
               state_ff <= (cell_visible && id_ok) ? SRCH_RD : IDLE;
            end
            SRCH_RD: begin
               state_ff <= (srch_ff == set_count_ff) ? IDLE : SRCH_CMP;
            end
            SRCH_CMP: begin
               if (set_hit) begin
                  res_ff.set_index <= srch_ff[SET_BITS-1:0];
                  opnd_a_ff <= req_ff.tile_id - rd_data_ff.first_id[ID_BITS-1:0];
                  opnd_b_ff <= rd_data_ff.columns;
                  state_ff  <= CELL_DIV_GO;
               end else begin
                  srch_ff  <= srch_ff + 1'b1;
                  state_ff <= SRCH_RD;
               end
            end
            CELL_DIV_GO: begin
               state_ff <= CELL_DIV_WAIT;
            end
            CELL_DIV_WAIT: begin
               if (div_rsp.done) begin
                  opnd_a_ff <= div_rsp.quotient;
                  opnd_b_ff <= div_rsp.remainder;
                  state_ff  <= MUL_SX;
               end
            end
            MUL_SX: begin
               res_ff.source_x <= product[15:0];
               state_ff <= MUL_SY;
            end
            MUL_SY: begin
               res_ff.source_y <= product[15:0];
               state_ff <= MUL_DX;
            end
            MUL_DX: begin
               res_ff.dest_x <= product[19:0];
               state_ff <= MUL_DY;
            end
            MUL_DY: begin
               // hold here until the output register is free
               if (rsp_load) begin
                  rsp_ff       <= '{set_index: res_ff.set_index,
                                    source_x:  res_ff.source_x,
                                    source_y:  res_ff.source_y,
                                    dest_x:    res_ff.dest_x,
                                    dest_y:    product[19:0]};
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      set_count_ff <= COUNT_BITS'(MAX_SETS))
      else $error("set count above table size");

   a_load_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == LOAD_WRITE |=> set_count_ff == $past(set_count_ff) + 1'b1)
      else $error("load did not advance set count");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == LOAD_COLS_WAIT || state_ff == LOAD_ROWS_WAIT ||
                        state_ff == CELL_DIV_WAIT))
      else $error("divider finished outside a wait state");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MUL_DY && rsp_valid_ff && !rsp_ready) |=> state_ff == MUL_DY)
      else $error("result overwrote a pending word");
`endif

endmodule

### tb/sv/tile_map_sprite_address_gen_core_tb.sv
module tile_map_sprite_address_gen_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tmsag_pkg::*;

   localparam realtime HALF_PERIOD     = 6.0;
   localparam int      SETTLE_CYCLES   = 100;
   localparam int      CYCLE_LIMIT     = 600000;
   localparam int      HOLD_OFF_CYCLES = 400;
   localparam int      HOLD_OFF_AFTER  = 150;
   localparam int      MAX_REPORTS     = 10;
   localparam int      VIEW_PHASES     = 9;

   typedef enum logic {STEP_WORD, STEP_CSR} step_kind_type;
   typedef enum logic [1:0] {CHK_PREDICT, CHK_DROP, CHK_TILE} step_check_type;

   typedef struct {
      step_kind_type  what;
      req_type        word;
      logic [2:0]     reg_index;
      logic [31:0]    reg_value;
      step_check_type check;
      rsp_type        tile;
   } step_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tile_map_sprite_address_gen_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // shadow of the block's registers and tileset table
   logic [8:0]         tile_w      = 9'd16;
   logic [8:0]         tile_h      = 9'd16;
   logic [12:0]        map_w       = 13'd64;
   logic [12:0]        map_h       = 13'd64;
   logic signed [15:0] view_l      = 16'sd0;
   logic signed [15:0] view_t      = 16'sd0;
   logic [14:0]        view_w      = 15'd64;
   logic [14:0]        view_h      = 15'd64;
   logic [16:0]        first_id [MAX_SETS];
   logic [16:0]        last_id  [MAX_SETS];
   logic [15:0]        set_cols [MAX_SETS];
   logic [3:0]         sets_loaded = '0;
   logic [15:0]        id_total    = '0;

   rsp_type  pending_tiles [$];
   step_type plan [$];

   int burst_left    = 0;
   int mismatches    = 0;
   int tiles_checked = 0;
   int words_taken   = 0;
   int hold_left     = 0;
   bit held_off      = 1'b0;
   int pattern_left  = 0;
   int stall_pct     = 0;
   int cycle_count   = 0;

   function automatic void add_step(input step_type s);
      plan = {plan, s};
   endfunction

   function automatic void expect_tile(input rsp_type t);
      pending_tiles = {pending_tiles, t};
   endfunction

   function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_TILE_WIDTH:  tile_w = value[8:0];
         REG_TILE_HEIGHT: tile_h = value[8:0];
         REG_MAP_WIDTH:   map_w  = value[12:0];
         REG_MAP_HEIGHT:  map_h  = value[12:0];
         REG_VIEW_LEFT:   view_l = value[15:0];
         REG_VIEW_TOP:    view_t = value[15:0];
         REG_VIEW_WIDTH:  view_w = value[14:0];
         REG_VIEW_HEIGHT: view_h = value[14:0];
         default: ;
      endcase
   endfunction

   function automatic void append_tileset(input logic [15:0] tex_w, input logic [15:0] tex_h);
      logic [15:0] cols, rows;
      logic [32:0] last;
      if (sets_loaded >= MAX_SETS) return;
      cols = (tile_w != 0) ? tex_w / tile_w : 16'd0;
      rows = (tile_h != 0) ? tex_h / tile_h : 16'd0;
      last = 33'(id_total) + 33'(cols) * 33'(rows);
      // id total saturates, later sets come out empty
      if (last > 33'(ID_MAX)) last = 33'(ID_MAX);
      first_id[sets_loaded] = 17'(id_total) + 17'd1;
      last_id[sets_loaded]  = last[16:0];
      set_cols[sets_loaded] = cols;
      id_total = last[15:0];
      sets_loaded++;
   endfunction

   // view window clipped to the map, upper bounds exclusive
   function automatic void visible_span(output logic signed [17:0] lo_c, hi_c, lo_r, hi_r);
      lo_c = view_l;
      if (lo_c < 0) lo_c = 0;
      hi_c = view_l + $signed({1'b0, view_w});
      if (hi_c > $signed({5'b0, map_w})) hi_c = $signed({5'b0, map_w});
      lo_r = view_t;
      if (lo_r < 0) lo_r = 0;
      hi_r = view_t + $signed({1'b0, view_h});
      if (hi_r > $signed({5'b0, map_h})) hi_r = $signed({5'b0, map_h});
   endfunction

   function automatic bit locate_tile(input req_type w, output rsp_type tile);
      logic signed [17:0] lo_c, hi_c, lo_r, hi_r, col, row;
      logic [15:0]        off, cols;
      int                 hit, k;
      hit  = -1;
      tile = '0;
      visible_span(lo_c, hi_c, lo_r, hi_r);
      col = $signed({6'b0, w.cell_column});
      row = $signed({6'b0, w.cell_row});
      if (col < lo_c || col >= hi_c || row < lo_r || row >= hi_r) return 1'b0;
      if (w.tile_id == 0 || w.tile_id > id_total) return 1'b0;
      for (k = 0; k < sets_loaded; k++)
         if (hit < 0 && 17'(w.tile_id) >= first_id[k] && 17'(w.tile_id) <= last_id[k])
            hit = k;
      if (hit < 0) return 1'b0;
      off  = w.tile_id - first_id[hit][15:0];
      cols = set_cols[hit];
      tile.set_index = hit[2:0];
      if (cols != 0) begin
         tile.source_x = (off % cols) * tile_w;
         tile.source_y = (off / cols) * tile_h;
      end
      tile.dest_x = w.cell_column * tile_w;
      tile.dest_y = w.cell_row * tile_h;
      return 1'b1;
   endfunction

   function automatic void take_word(input req_type w, input step_check_type check,
                                     input rsp_type typed);
      rsp_type tile;
      bit      found;
      found = 1'b0;
      if (w.kind == KIND_LOAD) append_tileset(w.texture_width, w.texture_height);
      else found = locate_tile(w, tile);
      words_taken++;
      case (check)
         CHK_PREDICT: if (found) expect_tile(tile);
         CHK_TILE:    expect_tile(typed);
         default:     ;
      endcase
   endfunction

   function automatic void note_mismatch(input string what, input rsp_type want,
                                         input rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("[%0t] %s: expected set %0d src (%0d,%0d) dst (%0d,%0d),",
                  $realtime, what, want.set_index, want.source_x, want.source_y,
                  want.dest_x, want.dest_y);
         $display("   got set %0d src (%0d,%0d) dst (%0d,%0d)",
                  got.set_index, got.source_x, got.source_y, got.dest_x, got.dest_y);
      end
   endfunction

   function automatic void check_tile(input rsp_type got);
      rsp_type want;
      tiles_checked++;
      if (pending_tiles.size() == 0) begin
         note_mismatch("word with nothing pending", '0, got);
         return;
      end
      want = pending_tiles.pop_front();
      if (got.set_index !== want.set_index || got.source_x !== want.source_x ||
          got.source_y !== want.source_y || got.dest_x !== want.dest_x ||
          got.dest_y !== want.dest_y)
         note_mismatch("tile differs", want, got);
   endfunction

   function automatic req_type cell_word(input int c, input int r, input int id);
      req_type w;
      w             = '0;
      w.kind        = KIND_CELL;
      w.cell_column = 12'(c);
      w.cell_row    = 12'(r);
      w.tile_id     = 16'(id);
      return w;
   endfunction

   function automatic req_type load_word(input int tex_w, input int tex_h);
      req_type w;
      w                = '0;
      w.kind           = KIND_LOAD;
      w.texture_width  = 16'(tex_w);
      w.texture_height = 16'(tex_h);
      return w;
   endfunction

   function automatic req_type random_word(input logic kind);
      req_type     w;
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      w      = bits[$bits(req_type)-1:0];
      w.kind = kind;
      return w;
   endfunction

   // cells mostly land in the window and on ids that some set owns
   function automatic req_type random_cell();
      req_type            w;
      logic signed [17:0] lo_c, hi_c, lo_r, hi_r;
      int                 k;
      w = random_word(KIND_CELL);
      visible_span(lo_c, hi_c, lo_r, hi_r);
      if (hi_c > 4096) hi_c = 4096;
      if (hi_r > 4096) hi_r = 4096;
      if (lo_c < hi_c && $urandom_range(0, 3) != 0)
         w.cell_column = 12'($urandom_range(lo_c, hi_c - 1));
      if (lo_r < hi_r && $urandom_range(0, 3) != 0)
         w.cell_row = 12'($urandom_range(lo_r, hi_r - 1));
      if (sets_loaded != 0 && $urandom_range(0, 3) != 0) begin
         k = $urandom_range(0, sets_loaded - 1);
         if (first_id[k] <= last_id[k])
            w.tile_id = 16'($urandom_range(first_id[k], last_id[k]));
      end
      return w;
   endfunction

   function automatic step_type word_step(input req_type w, input step_check_type check,
                                          input rsp_type tile);
      step_type s;
      s.what      = STEP_WORD;
      s.word      = w;
      s.reg_index = REG_TILE_WIDTH;
      s.reg_value = '0;
      s.check     = check;
      s.tile      = tile;
      return s;
   endfunction

   function automatic step_type csr_step(input logic [2:0] idx, input logic [31:0] value);
      step_type s;
      s           = word_step('0, CHK_DROP, '0);
      s.what      = STEP_CSR;
      s.reg_index = idx;
      s.reg_value = value;
      return s;
   endfunction

   task automatic offer_word(input req_type w, input step_check_type check,
                             input rsp_type typed);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      take_word(w, check, typed);
   endtask

   // a dropped cell leaves no trace, so give the block its latency after the last word
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_tiles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      apply_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic program_view(input int tw, th, mw, mh, vl, vt, vw, vh);
      write_reg(REG_TILE_WIDTH, tw);
      write_reg(REG_TILE_HEIGHT, th);
      write_reg(REG_MAP_WIDTH, mw);
      write_reg(REG_MAP_HEIGHT, mh);
      write_reg(REG_VIEW_LEFT, vl);
      write_reg(REG_VIEW_TOP, vt);
      write_reg(REG_VIEW_WIDTH, vw);
      write_reg(REG_VIEW_HEIGHT, vh);
   endtask

   // receiver: changing stall pattern, one long hold-off to back the block up
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_tile(rsp_data);
         if (!held_off && tiles_checked >= HOLD_OFF_AFTER) begin
            held_off  = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               case ($urandom_range(0, 2))
                  0:       stall_pct = 0;
                  1:       stall_pct = 30;
                  default: stall_pct = 80;
               endcase
               pattern_left = 64;
            end
            pattern_left--;
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      rsp_type no_tile;
      int      phase, left, i;
      int      phase_items [VIEW_PHASES];
      no_tile     = '0;
      phase_items = '{100, 100, 30, 60, 52, 52, 52, 52, 52};
      for (i = 0; i < MAX_SETS; i++) begin
         first_id[i] = '0;
         last_id[i]  = '0;
         set_cols[i] = '0;
      end

      // nothing loaded yet, blank id
      add_step(word_step(cell_word(0, 0, 1), CHK_DROP, no_tile));
      add_step(word_step(cell_word(0, 0, 0), CHK_DROP, no_tile));
      // set 0: 4 x 2 tiles, ids 1..8
      add_step(word_step(load_word(64, 32), CHK_DROP, no_tile));
      add_step(word_step(cell_word(0, 0, 1), CHK_TILE, no_tile));
      add_step(word_step(cell_word(63, 63, 8), CHK_PREDICT, no_tile));
      add_step(word_step(cell_word(64, 0, 1), CHK_DROP, no_tile));
      add_step(word_step(cell_word(0, 64, 1), CHK_DROP, no_tile));
      add_step(word_step(cell_word(0, 0, 9), CHK_DROP, no_tile));
      // empty sets: zero texture, then zero tile width
      add_step(word_step(load_word(0, 0), CHK_DROP, no_tile));
      add_step(csr_step(REG_TILE_WIDTH, 0));
      add_step(word_step(load_word(100, 100), CHK_DROP, no_tile));
      add_step(csr_step(REG_TILE_WIDTH, 16));
      add_step(word_step(load_word(160, 48), CHK_DROP, no_tile));
      add_step(word_step(load_word(1000, 500), CHK_DROP, no_tile));
      // saturates the id total, the next two sets come out empty
      add_step(word_step(load_word(65535, 65535), CHK_DROP, no_tile));
      add_step(word_step(load_word(32, 32), CHK_DROP, no_tile));
      add_step(word_step(load_word(65535, 65535), CHK_DROP, no_tile));
      // table full
      add_step(word_step(load_word(64, 64), CHK_DROP, no_tile));
      add_step(word_step(cell_word(5, 5, 9), CHK_TILE,
                         '{3'd3, 16'd0, 16'd0, 20'd80, 20'd80}));
      add_step(word_step(cell_word(5, 5, 38), CHK_PREDICT, no_tile));
      add_step(word_step(cell_word(6, 7, 39), CHK_PREDICT, no_tile));
      add_step(word_step(cell_word(63, 0, 65535), CHK_PREDICT, no_tile));
      add_step(word_step(cell_word(2, 9, 1960), CHK_PREDICT, no_tile));
      // window hanging off the left edge of the map
      add_step(csr_step(REG_VIEW_LEFT, 32'hFFFF_FFFB));
      add_step(csr_step(REG_VIEW_WIDTH, 10));
      add_step(word_step(cell_word(4, 0, 10), CHK_PREDICT, no_tile));
      add_step(word_step(cell_word(5, 0, 10), CHK_DROP, no_tile));
      add_step(csr_step(REG_MAP_WIDTH, 4096));
      add_step(csr_step(REG_VIEW_LEFT, 0));
      add_step(csr_step(REG_VIEW_WIDTH, 32767));
      add_step(word_step(cell_word(4095, 0, 65535), CHK_PREDICT, no_tile));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[p]) begin
         if (plan[p].what == STEP_CSR) begin
            settle();
            write_reg(plan[p].reg_index, plan[p].reg_value);
         end else begin
            offer_word(plan[p].word, plan[p].check, plan[p].tile);
         end
      end

      for (phase = 0; phase < VIEW_PHASES; phase++) begin
         settle();
         case (phase)
            0: program_view(1, 1, 1, 1, 0, 0, 1, 1);
            1: program_view(511, 511, 8191, 8191, 0, 0, 32767, 32767);
            2: program_view(0, 0, 4096, 4096, -32768, 32767, 0, 0);
            3: program_view(0, 0, 4096, 4096, -40, -7, 1000, 32767);
            default:
               program_view($urandom_range(0, 300), $urandom_range(0, 300),
                            $urandom_range(1, 4096), $urandom_range(1, 4096),
                            int'($urandom_range(0, 600)) - 100,
                            int'($urandom_range(0, 600)) - 100,
                            $urandom_range(0, 4200), $urandom_range(0, 4200));
         endcase
         left = phase_items[phase];
         while (left > 0) begin
            // loads only hit a full table by now
            if ($urandom_range(0, 15) == 0) begin
               offer_word(random_word(KIND_LOAD), CHK_PREDICT, no_tile);
            end else begin
               offer_word(random_cell(), CHK_PREDICT, no_tile);
               left--;
            end
         end
      end

      settle();
      $display("covered %0d words over %0d view settings, %0d tiles compared", words_taken,
               VIEW_PHASES + 1, tiles_checked);
      $display("table ended with %0d sets and id total %0d", sets_loaded, id_total);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
hw/rtl/tmsag_pkg.sv
hw/rtl/tmsag_divider.sv
hw/rtl/tile_map_sprite_address_gen_core.sv
tb/sv/tile_map_sprite_address_gen_core_tb.sv
